/* rtl/rti_pkg.sv */
package rti_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int DIST_WIDTH      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int NUM_REGS        = 4;
  localparam int CFG_AWIDTH      = 5;
  localparam int CFG_DWIDTH      = 64;

  // Register byte addresses (8-byte stride)
  localparam logic [CFG_AWIDTH-1:0] ADDR_VERTEX_A     = 5'd0;
  localparam logic [CFG_AWIDTH-1:0] ADDR_VERTEX_B     = 5'd8;
  localparam logic [CFG_AWIDTH-1:0] ADDR_VERTEX_C     = 5'd16;
  localparam logic [CFG_AWIDTH-1:0] ADDR_PLANE_NORMAL = 5'd24;

  typedef enum logic [1:0] {
    CAUSE_HIT      = 2'd0,
    CAUSE_PARALLEL = 2'd1,
    CAUSE_BEHIND   = 2'd2,
    CAUSE_OUTSIDE  = 2'd3
  } cause_t;

endpackage

/* rtl/rti_ray_if.sv */
interface rti_ray_if #(
  parameter int W = rti_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

/* rtl/rti_res_if.sv */
interface rti_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] distance;
  logic [1:0]  miss_cause;

  modport source (output valid, hit, distance, miss_cause, input ready);
  modport sink   (input valid, hit, distance, miss_cause, output ready);
endinterface

/* rtl/rti_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, saturated to
// DIST_WIDTH bits. Advances when adv is high. Quotient of (n << 16) / d.
module rti_divider #(
  parameter int NW = 34,
  parameter int DW = 33
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [NW-1:0]                     in_num,
  input  logic [DW-1:0]                     in_den,
  output logic                              out_valid,
  output logic [rti_pkg::DIST_WIDTH-1:0]    out_quot
);
  localparam int QW = rti_pkg::DIST_WIDTH;
  localparam int DV = NW + rti_pkg::FRAC_BITS;  // dividend width
  localparam int RW = DW + 1;

  // Quotient bits above QW imply saturation. Test (n<<16) >= d<<QW up front.
  logic [DV-1:0] dvd;
  logic          sat0;
  assign dvd  = {in_num, {rti_pkg::FRAC_BITS{1'b0}}};
  assign sat0 = ({{(QW){1'b0}}, dvd} >= ({{(DV){1'b0}}, in_den} << QW));

  logic [RW-1:0]   rem_r  [QW+1];
  logic [DV-1:0]   dvd_r  [QW+1];
  logic [DW-1:0]   den_r  [QW+1];
  logic [QW-1:0]   quo_r  [QW+1];
  logic            sat_r  [QW+1];
  logic            vld_r  [QW+1];

  // Stage 0: load; remainder takes the dividend bits above QW (below d unless saturating)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
    if (adv) begin
      rem_r[0] <= RW'(dvd >> QW);
      dvd_r[0] <= dvd;
      den_r[0] <= in_den;
      quo_r[0] <= '0;
      sat_r[0] <= sat0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [RW:0]   trial;
    logic          ge;
    assign trial = {rem_r[s], dvd_r[s][QW-1-s]};
    assign ge    = trial >= {2'b00, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= vld_r[s];
      end
      if (adv) begin
        rem_r[s+1] <= ge ? RW'(trial - {2'b00, den_r[s]}) : RW'(trial);
        dvd_r[s+1] <= dvd_r[s];
        den_r[s+1] <= den_r[s];
        quo_r[s+1] <= {quo_r[s][QW-2:0], ge};
        sat_r[s+1] <= sat_r[s];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quot  = sat_r[QW] ? {QW{1'b1}} : quo_r[QW];
endmodule

/* rtl/ray_triangle_intersect.sv */
// Channel  | Direction | Payload
// in_      | sink      | origin_x/y/z, dir_x/y/z (COORD_WIDTH signed each)
// out_     | source    | hit, distance[31:0], miss_cause[1:0]
// cfg_     | APB write | vertex_a/b/c, plane_normal at 8-byte stride
// One ray per cycle while the output is not stalled. The pipe holds six arithmetic stages,
// the divider (a load stage and 32 bit-per-stage steps), and the output register.
// rst_n is synchronous; it clears valid bits and configuration registers.
// The whole pipe advances together when the output register is free or taken,
// so a stalled output freezes every stage and nothing is lost or repeated.
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rti_ray_if.sink                            in_ray,
  rti_res_if.source                          out_res,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rti_pkg::CFG_AWIDTH-1:0]     cfg_paddr,
  input  logic [rti_pkg::CFG_DWIDTH-1:0]     cfg_pwdata,
  output logic [rti_pkg::CFG_DWIDTH-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  localparam int W   = COORD_WIDTH;
  localparam int RGW = 3 * W;
  localparam int DW1 = W + 1;           // difference
  localparam int PW  = 2 * W + 4;       // dot products and cross terms
  localparam int TW  = 3 * W + 8;       // triple products
  localparam int SW  = 5 * W + 16;      // edge sums
  localparam int NW  = 2 * W + 2;       // |num|
  localparam int DDW = 2 * W + 1;       // |den|
  localparam int LW  = TW / 2;          // low slice of a triple product
  localparam int HW  = TW - LW;         // high slice of a triple product
  localparam int PHW = HW + PW;         // high partial product
  localparam int PLW = LW + 1 + PW;     // low partial product

  // Configuration registers
  logic [RGW-1:0] va_r, vb_r, vc_r, vn_r;
  logic           wr;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0; vb_r <= '0; vc_r <= '0; vn_r <= '0;
    end else if (wr) begin
      unique case (cfg_paddr)
        rti_pkg::ADDR_VERTEX_A:     va_r <= cfg_pwdata[RGW-1:0];
        rti_pkg::ADDR_VERTEX_B:     vb_r <= cfg_pwdata[RGW-1:0];
        rti_pkg::ADDR_VERTEX_C:     vc_r <= cfg_pwdata[RGW-1:0];
        rti_pkg::ADDR_PLANE_NORMAL: vn_r <= cfg_pwdata[RGW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      rti_pkg::ADDR_VERTEX_A:     cfg_prdata = rti_pkg::CFG_DWIDTH'(va_r);
      rti_pkg::ADDR_VERTEX_B:     cfg_prdata = rti_pkg::CFG_DWIDTH'(vb_r);
      rti_pkg::ADDR_VERTEX_C:     cfg_prdata = rti_pkg::CFG_DWIDTH'(vc_r);
      rti_pkg::ADDR_PLANE_NORMAL: cfg_prdata = rti_pkg::CFG_DWIDTH'(vn_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Unpacked coordinates
  logic signed [W-1:0] a [3], b [3], c [3], n [3];
  for (genvar k = 0; k < 3; k++) begin : g_unp
    assign a[k] = va_r[k*W +: W];
    assign b[k] = vb_r[k*W +: W];
    assign c[k] = vc_r[k*W +: W];
    assign n[k] = vn_r[k*W +: W];
  end

  // Global advance: pipe moves when output register is empty or taken
  logic adv;
  logic ovld_r;
  assign adv          = !ovld_r || out_res.ready;
  assign in_ray.ready = adv;

  // ---------------- Stage 1: register ray, differences
  logic                 v1_r;
  logic signed [W-1:0]  d1_r [3];
  logic signed [DW1-1:0] ra1_r [3], rb1_r [3], rc1_r [3];
  logic signed [DW1-1:0] ea1_r [3], eb1_r [3], ec1_r [3];
  logic signed [W-1:0]  o_in [3], d_in [3];
  assign o_in[0] = in_ray.origin_x; assign o_in[1] = in_ray.origin_y;
  assign o_in[2] = in_ray.origin_z;
  assign d_in[0] = in_ray.dir_x; assign d_in[1] = in_ray.dir_y;
  assign d_in[2] = in_ray.dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ray.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]  <= d_in[k];
        ra1_r[k] <= DW1'(o_in[k]) - DW1'(a[k]);
        rb1_r[k] <= DW1'(o_in[k]) - DW1'(b[k]);
        rc1_r[k] <= DW1'(o_in[k]) - DW1'(c[k]);
        ea1_r[k] <= DW1'(b[k]) - DW1'(a[k]);
        eb1_r[k] <= DW1'(c[k]) - DW1'(b[k]);
        ec1_r[k] <= DW1'(a[k]) - DW1'(c[k]);
      end
    end
  end

  // ---------------- Stage 2: products n*d, n*(a-o), cross products
  // Edge e x r and e x d components as registered pairs of products
  logic                  v2_r;
  logic signed [PW-1:0]  den_p2_r [3], num_p2_r [3];
  logic signed [PW-1:0]  cr2_r [3][3], cd2_r [3][3];  // [edge][component]
  logic signed [DW1-1:0] er [3][3], rr [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      er[0][k] = ea1_r[k]; er[1][k] = eb1_r[k]; er[2][k] = ec1_r[k];
      rr[0][k] = ra1_r[k]; rr[1][k] = rb1_r[k]; rr[2][k] = rc1_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        den_p2_r[k] <= PW'(n[k]) * PW'(d1_r[k]);
        num_p2_r[k] <= -(PW'(n[k]) * PW'(ra1_r[k]));
      end
      for (int e = 0; e < 3; e++) begin
        cr2_r[e][0] <= PW'(er[e][1]) * PW'(rr[e][2]) - PW'(er[e][2]) * PW'(rr[e][1]);
        cr2_r[e][1] <= PW'(er[e][2]) * PW'(rr[e][0]) - PW'(er[e][0]) * PW'(rr[e][2]);
        cr2_r[e][2] <= PW'(er[e][0]) * PW'(rr[e][1]) - PW'(er[e][1]) * PW'(rr[e][0]);
        cd2_r[e][0] <= PW'(er[e][1]) * PW'(d1_r[2]) - PW'(er[e][2]) * PW'(d1_r[1]);
        cd2_r[e][1] <= PW'(er[e][2]) * PW'(d1_r[0]) - PW'(er[e][0]) * PW'(d1_r[2]);
        cd2_r[e][2] <= PW'(er[e][0]) * PW'(d1_r[1]) - PW'(er[e][1]) * PW'(d1_r[0]);
      end
    end
  end

  // ---------------- Stage 3: sums for den/num, n-weighted cross terms
  logic                 v3_r;
  logic signed [PW-1:0] den3_r, num3_r;
  logic signed [TW-1:0] tr3_r [3], td3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      den3_r <= den_p2_r[0] + den_p2_r[1] + den_p2_r[2];
      num3_r <= num_p2_r[0] + num_p2_r[1] + num_p2_r[2];
      for (int e = 0; e < 3; e++) begin
        tr3_r[e] <= TW'(n[0]) * TW'(cr2_r[e][0]) + TW'(n[1]) * TW'(cr2_r[e][1])
                  + TW'(n[2]) * TW'(cr2_r[e][2]);
        td3_r[e] <= TW'(n[0]) * TW'(cd2_r[e][0]) + TW'(n[1]) * TW'(cd2_r[e][1])
                  + TW'(n[2]) * TW'(cd2_r[e][2]);
      end
    end
  end

  // ---------------- Stage 4a: partial products of den*tr and num*td
  // Split each triple product into a signed high half and an unsigned low half
  logic                  v4p_r;
  logic signed [PW-1:0]  den4p_r, num4p_r;
  logic signed [PHW-1:0] ph4_r [3], qh4_r [3];
  logic signed [PLW-1:0] pl4_r [3], ql4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v4p_r <= 1'b0;
    else if (adv) v4p_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      den4p_r <= den3_r;
      num4p_r <= num3_r;
      for (int e = 0; e < 3; e++) begin
        ph4_r[e] <= PHW'($signed(tr3_r[e][TW-1:LW])) * PHW'(den3_r);
        pl4_r[e] <= PLW'($signed({1'b0, tr3_r[e][LW-1:0]})) * PLW'(den3_r);
        qh4_r[e] <= PHW'($signed(td3_r[e][TW-1:LW])) * PHW'(num3_r);
        ql4_r[e] <= PLW'($signed({1'b0, td3_r[e][LW-1:0]})) * PLW'(num3_r);
      end
    end
  end

  // ---------------- Stage 4b: edge sums den*tr + num*td
  logic                 v4_r;
  logic signed [PW-1:0] den4_r, num4_r;
  logic signed [SW-1:0] s4_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v4p_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      den4_r <= den4p_r;
      num4_r <= num4p_r;
      for (int e = 0; e < 3; e++)
        s4_r[e] <= (SW'(ph4_r[e]) <<< LW) + SW'(pl4_r[e])
                 + (SW'(qh4_r[e]) <<< LW) + SW'(ql4_r[e]);
    end
  end

  // ---------------- Stage 5: classify, magnitudes
  logic               v5_r;
  rti_pkg::cause_t    cause5_r;
  logic [NW-1:0]      un5_r;
  logic [DDW-1:0]     ud5_r;
  rti_pkg::cause_t    cause5_nxt;
  logic               outside;

  always_comb begin
    outside = 1'b0;
    for (int e = 0; e < 3; e++)
      if ((s4_r[e] < 0 && den4_r > 0) || (s4_r[e] > 0 && den4_r < 0)) outside = 1'b1;
    priority if (den4_r == 0)
      cause5_nxt = rti_pkg::CAUSE_PARALLEL;
    else if ((num4_r > 0 && den4_r < 0) || (num4_r < 0 && den4_r > 0))
      cause5_nxt = rti_pkg::CAUSE_BEHIND;
    else if (outside)
      cause5_nxt = rti_pkg::CAUSE_OUTSIDE;
    else
      cause5_nxt = rti_pkg::CAUSE_HIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cause5_r <= cause5_nxt;
      un5_r    <= NW'(num4_r < 0 ? -num4_r : num4_r);
      // Keep divisor nonzero on parallel rays; result is discarded
      ud5_r    <= (den4_r == 0) ? DDW'(1) : DDW'(den4_r < 0 ? -den4_r : den4_r);
    end
  end

  // ---------------- Divider with a side pipe for the cause
  logic                           dv_valid;
  logic [rti_pkg::DIST_WIDTH-1:0] dv_quot;
  rti_pkg::cause_t                cp_r [rti_pkg::DIST_WIDTH+1];

  rti_divider #(.NW(NW), .DW(DDW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (v5_r),
    .in_num   (un5_r),
    .in_den   (ud5_r),
    .out_valid(dv_valid),
    .out_quot (dv_quot)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      cp_r[0] <= cause5_r;
      for (int s = 0; s < rti_pkg::DIST_WIDTH; s++) cp_r[s+1] <= cp_r[s];
    end
  end

  // ---------------- Output register
  logic                           ohit_r;
  logic [rti_pkg::DIST_WIDTH-1:0] odist_r;
  rti_pkg::cause_t                ocause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (adv) ovld_r <= dv_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ohit_r   <= (cp_r[rti_pkg::DIST_WIDTH] == rti_pkg::CAUSE_HIT);
      odist_r  <= (cp_r[rti_pkg::DIST_WIDTH] == rti_pkg::CAUSE_HIT) ? dv_quot : '0;
      ocause_r <= cp_r[rti_pkg::DIST_WIDTH];
    end
  end

  assign out_res.valid      = ovld_r;
  assign out_res.hit        = ohit_r;
  assign out_res.distance   = odist_r;
  assign out_res.miss_cause = ocause_r;

  // Assertions
  a_hit_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.hit == (out_res.miss_cause == rti_pkg::CAUSE_HIT)))
    else $error("hit flag disagrees with miss cause");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.hit) |-> (out_res.distance == '0))
    else $error("nonzero distance on miss");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |=> (out_res.valid && $stable(out_res.distance)))
    else $error("result changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_res.valid |-> in_ray.ready)
    else $error("input blocked with empty output");
endmodule
